>>> sv/hcbp_pkg.sv
// shared constants, command codes and the result item type of the huffman bit packer
// depends on nothing; used by every module of the block
`default_nettype none

package hcbp_pkg;

    localparam int MAX_CODE_LEN = 16;
    localparam int SYMBOL_COUNT = 128;

    localparam int CMD_W    = 2;
    localparam int SYMBOL_W = 8;
    localparam int CODE_W   = 16;
    localparam int LEN_W    = 5;
    localparam int BYTE_W   = 8;
    localparam int TOTAL_W  = 32;

    localparam int SYM_W     = $clog2(SYMBOL_COUNT);
    localparam int ENC_LIMIT = (SYMBOL_COUNT < 128) ? SYMBOL_COUNT : 128;

    localparam int PART_W     = BYTE_W - 1;
    localparam int PBITS_W    = $clog2(BYTE_W);
    localparam int ACC_W      = PART_W + MAX_CODE_LEN;
    localparam int N_W        = $clog2(ACC_W + 1);
    localparam int RES_MAX    = ACC_W / BYTE_W;
    localparam int CNT_W      = $clog2(RES_MAX + 1);
    localparam int FIFO_DEPTH = 1 << $clog2(2 * RES_MAX);
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               last;
        logic [TOTAL_W-1:0] total_bits;
    } result_t;

endpackage

`default_nettype wire

>>> sv/hcbp_table.sv
// code table: one code and length per symbol, registered read, per-entry valid bits
// depends on hcbp_pkg
`default_nettype none

module hcbp_table (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       wr_en,
    input  wire logic [hcbp_pkg::SYM_W-1:0] wr_addr,
    input  wire logic [hcbp_pkg::CODE_W-1:0] wr_code,
    input  wire logic [hcbp_pkg::LEN_W-1:0] wr_len,
    input  wire logic                       rd_en,
    input  wire logic [hcbp_pkg::SYM_W-1:0] rd_addr,
    output logic      [hcbp_pkg::CODE_W-1:0] rd_code,
    output logic      [hcbp_pkg::LEN_W-1:0] rd_len
);
    import hcbp_pkg::*;

    logic [CODE_W+LEN_W-1:0] mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] valid_reg;
    logic [CODE_W+LEN_W-1:0] rd_data_reg;
    logic                    rd_hit_reg;
    logic [CODE_W-1:0]       code_mask;

    assign code_mask = (CODE_W'(1) << wr_len) - CODE_W'(1);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_len, wr_code & code_mask};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_code = rd_hit_reg ? rd_data_reg[CODE_W-1:0] : '0;
    assign rd_len  = rd_hit_reg ? rd_data_reg[CODE_W+LEN_W-1:CODE_W] : '0;

endmodule

`default_nettype wire

>>> sv/hcbp_fifo.sv
// result queue: takes up to RES_MAX result items a cycle, gives one a cycle while pop is high
// depends on hcbp_pkg
`default_nettype none

module hcbp_fifo (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic [hcbp_pkg::CNT_W-1:0]           push_cnt,
    input  wire hcbp_pkg::result_t [hcbp_pkg::RES_MAX-1:0] push_data,
    input  wire logic                                 pop,
    output hcbp_pkg::result_t                         head,
    output logic                                      not_empty,
    output logic                                      room
);
    import hcbp_pkg::*;

    result_t            mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0]  count_reg, count_next;
    logic               do_pop;

    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign room      = (count_reg <= FCNT_W'(FIFO_DEPTH - RES_MAX));
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
        count_next  = count_reg + FCNT_W'(push_cnt) - FCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < RES_MAX; i++) begin
            if (CNT_W'(i) < push_cnt) begin
                mem_reg[wr_ptr_reg + PTR_W'(i)] <= push_data[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/huffman_code_bit_packer_unit.sv
// top level of the huffman code bit packer: command decode, bit accumulator, total count
// depends on hcbp_pkg, hcbp_table and hcbp_fifo
`default_nettype none

// Takes one command item per cycle while s_ready is high. A load writes the code
// table on the cycle it is accepted and gives no result. An encode or flush reads the
// table into a registered stage, from which it reaches the bit accumulator once the
// queue has room; its result items enter a four-entry queue and leave one per cycle
// while m_ready is high, so an encode that completes two bytes gives two output items,
// and input stalls only when the queue lacks room for two items. The code table starts
// cleared through per-entry valid bits, so no clearing pass follows reset.
module huffman_code_bit_packer_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [hcbp_pkg::CMD_W-1:0]    s_command,
    input  wire logic [hcbp_pkg::SYMBOL_W-1:0] s_symbol,
    input  wire logic [hcbp_pkg::CODE_W-1:0]   s_code_value,
    input  wire logic [hcbp_pkg::LEN_W-1:0]    s_code_length,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [hcbp_pkg::BYTE_W-1:0]   m_out_byte,
    output logic                               m_byte_valid,
    output logic                               m_last,
    output logic      [hcbp_pkg::TOTAL_W-1:0]  m_total_bits
);
    import hcbp_pkg::*;

    logic               accept;
    logic               load_ok;
    logic               enc_ok;
    cmd_t               in_cmd;

    logic               s1_valid_reg, s1_valid_next;
    cmd_t               s1_cmd_reg;
    logic               s1_ok_reg;
    logic               fire;
    logic               room;

    logic [CODE_W-1:0]  rd_code;
    logic [LEN_W-1:0]   rd_len;

    logic [PART_W-1:0]  partial_byte_reg, partial_byte_next;
    logic [PBITS_W-1:0] partial_bits_reg, partial_bits_next;
    logic [TOTAL_W-1:0] bit_total_reg, bit_total_next;

    logic [LEN_W-1:0]   eff_len;
    logic [ACC_W-1:0]   acc;
    logic [N_W-1:0]     nbits;
    logic [TOTAL_W:0]   sum;
    logic [PART_W-1:0]  part_mask;
    logic [N_W-1:0]     shamt;

    logic [CNT_W-1:0]                push_cnt;
    result_t [RES_MAX-1:0]           push_data;
    result_t                         head;

    assign in_cmd  = cmd_t'(s_command);
    assign accept  = s_valid && s_ready;
    assign load_ok = (in_cmd == CMD_LOAD)
                  && ({1'b0, s_symbol} < (SYMBOL_W+1)'(SYMBOL_COUNT))
                  && ({1'b0, s_code_length} <= (LEN_W+1)'(MAX_CODE_LEN));
    assign enc_ok  = (s_symbol != '0)
                  && ({1'b0, s_symbol} < (SYMBOL_W+1)'(ENC_LIMIT));

    assign fire    = s1_valid_reg && room;
    assign s_ready = !s1_valid_reg || room;

    hcbp_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (accept && load_ok),
        .wr_addr (s_symbol[SYM_W-1:0]),
        .wr_code (s_code_value),
        .wr_len  (s_code_length),
        .rd_en   (accept),
        .rd_addr (s_symbol[SYM_W-1:0]),
        .rd_code (rd_code),
        .rd_len  (rd_len)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (fire) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cmd_reg <= in_cmd;
            s1_ok_reg  <= enc_ok;
        end
    end

    always_comb begin
        eff_len   = s1_ok_reg ? rd_len : '0;
        acc       = (ACC_W'(partial_byte_reg) << eff_len) | ACC_W'(rd_code);
        nbits     = N_W'(partial_bits_reg) + N_W'(eff_len);
        sum       = {1'b0, bit_total_reg} + (TOTAL_W+1)'(eff_len);
        part_mask = (PART_W'(1) << nbits[PBITS_W-1:0]) - PART_W'(1);
        shamt     = '0;

        partial_byte_next = partial_byte_reg;
        partial_bits_next = partial_bits_reg;
        bit_total_next    = bit_total_reg;
        push_cnt          = '0;
        push_data         = '0;

        if (fire) begin
            case (s1_cmd_reg)
                CMD_ENCODE: begin
                    if (eff_len != '0) begin
                        bit_total_next    = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                        partial_bits_next = nbits[PBITS_W-1:0];
                        partial_byte_next = acc[PART_W-1:0] & part_mask;
                        push_cnt          = CNT_W'(nbits >> PBITS_W);
                        for (int k = 0; k < RES_MAX; k++) begin
                            shamt = nbits - N_W'(BYTE_W * (k + 1));
                            push_data[k].out_byte   = BYTE_W'(acc >> shamt);
                            push_data[k].byte_valid = 1'b1;
                            push_data[k].last       = 1'b0;
                            push_data[k].total_bits = bit_total_next;
                        end
                    end
                end
                CMD_FLUSH: begin
                    push_cnt                = CNT_W'(1);
                    push_data[0].out_byte   = BYTE_W'(partial_byte_reg)
                                            << (4'(BYTE_W) - 4'(partial_bits_reg));
                    push_data[0].byte_valid = (partial_bits_reg != '0);
                    push_data[0].last       = 1'b1;
                    push_data[0].total_bits = bit_total_reg;
                    partial_byte_next       = '0;
                    partial_bits_next       = '0;
                    bit_total_next          = '0;
                end
                CMD_LOAD: begin
                end
                CMD_NOP: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg     <= 1'b0;
            partial_byte_reg <= '0;
            partial_bits_reg <= '0;
            bit_total_reg    <= '0;
        end else begin
            s1_valid_reg     <= s1_valid_next;
            partial_byte_reg <= partial_byte_next;
            partial_bits_reg <= partial_bits_next;
            bit_total_reg    <= bit_total_next;
        end
    end

    hcbp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push_data (push_data),
        .pop       (m_ready),
        .head      (head),
        .not_empty (m_valid),
        .room      (room)
    );

    assign m_out_byte   = head.out_byte;
    assign m_byte_valid = head.byte_valid;
    assign m_last       = head.last;
    assign m_total_bits = head.total_bits;

    a_accept_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted item did not reach the table stage");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && s1_cmd_reg == CMD_FLUSH) |=>
            (partial_bits_reg == '0 && partial_byte_reg == '0 && bit_total_reg == '0))
        else $error("flush left accumulator state behind");

    a_empty_flush_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last && !m_byte_valid) |-> (m_out_byte == '0))
        else $error("flush without pending bits gave a nonzero byte");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && !room))
        else $error("input stalled without a blocked table stage");

endmodule

`default_nettype wire
